@@ hw/rtl/dfi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfi_pkg: shared types and constants for the direct form one IIR filter
// Widths, tap counts, register indexes and the cell/result structs.
// ----------------------------------------------------------------------------
package dfi_pkg;

  // sample and coefficient formats
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;               // Q2.14
  localparam int FRAC_BITS  = 14;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int HIST_DEPTH = 4;
  // eight products of full range need three bits of growth
  localparam int ACC_W      = PROD_W + 3;
  localparam int SHIFT_W    = ACC_W - FRAC_BITS;

  // active taps
  localparam int FEED_TAPS  = 4;                // 1 .. HIST_DEPTH
  localparam int BACK_TAPS  = 4;                // 0 .. HIST_DEPTH

  // register file
  localparam int NUM_REGS   = 2 * HIST_DEPTH;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam logic [REG_IDX_W-1:0] REG_FEED_COEF_ZERO = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_BACK_COEF_ONE  = REG_IDX_W'(HIST_DEPTH);
  localparam logic signed [COEF_W-1:0] COEF_UNITY = COEF_W'(2 ** FRAC_BITS);

  // rounding and saturation
  localparam logic signed [ACC_W-1:0]    ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI  = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO  = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // output queue
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // shift strobes handed along the cell row
  typedef struct packed {
    logic x;    // new input sample enters the row
    logic y;    // new output sample enters the row
  } dfi_shift_t;

  // one finished result
  typedef struct packed {
    logic                       clipped;
    logic signed [SAMPLE_W-1:0] sample;
  } dfi_result_t;

endpackage

@@ hw/rtl/dfi_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfi_cell: one tap cell of the filter row
// Holds one input and one output history entry, passes them to the right
// neighbor on a shift, and registers its feed and feedback products.
// ----------------------------------------------------------------------------
module dfi_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  dfi_pkg::dfi_shift_t                 shift,
  input  logic signed [dfi_pkg::SAMPLE_W-1:0] x_left,
  input  logic signed [dfi_pkg::SAMPLE_W-1:0] y_left,
  input  logic signed [dfi_pkg::COEF_W-1:0]   feed_coef,
  input  logic signed [dfi_pkg::COEF_W-1:0]   back_coef,
  output logic signed [dfi_pkg::SAMPLE_W-1:0] x_hold,
  output logic signed [dfi_pkg::SAMPLE_W-1:0] y_hold,
  output logic signed [dfi_pkg::PROD_W-1:0]   feed_prod,
  output logic signed [dfi_pkg::PROD_W-1:0]   back_prod
);

  logic signed [dfi_pkg::SAMPLE_W-1:0] y_next;

  // feedback product tracks the value this cell holds after the edge
  assign y_next = shift.y ? y_left : y_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_hold <= '0;
      y_hold <= '0;
    end else begin
      if (shift.x) begin
        x_hold <= x_left;
      end
      if (shift.y) begin
        y_hold <= y_left;
      end
    end
  end

  // free-running product registers
  always_ff @(posedge clk) begin
    feed_prod <= feed_coef * x_hold;
    back_prod <= back_coef * y_next;
  end

endmodule

@@ hw/rtl/dfi_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfi_out_fifo: result queue on the output side
// Small register queue; the head is shown directly on the output.
// ----------------------------------------------------------------------------
module dfi_out_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  dfi_pkg::dfi_result_t         push_data,
  input  logic                         pop,
  output logic                         head_valid,
  output dfi_pkg::dfi_result_t         head_data,
  output logic [dfi_pkg::CNT_W-1:0]    count
);

  dfi_pkg::dfi_result_t           entry [dfi_pkg::FIFO_DEPTH];
  logic [dfi_pkg::PTR_W-1:0]      wr_ptr;
  logic [dfi_pkg::PTR_W-1:0]      rd_ptr;
  logic                           do_pop;

  assign head_valid = (count != '0);
  assign head_data  = entry[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == dfi_pkg::PTR_W'(dfi_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == dfi_pkg::PTR_W'(dfi_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/direct_form_one_iir_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_form_one_iir_filter: 4+4 tap direct form one IIR, Q2.14 coefficients
// Input stream s_*: one signed 16-bit sample per beat. Output stream m_*: the
// filtered sample (rounded half up, shifted by 14, saturated) and a clip flag.
// Coefficients are written through cfg_we/cfg_index/cfg_data, by the user only
// while idle; the block does not enforce this. 0..3 feed weights of x[n]..x[n-3],
// 4..7 weights subtracted for y[n-1]..y[n-4]. Throughput: one sample per cycle
// while s_tready is high. The limit is the recursion: final sum, rounding and
// saturation, then the feedback multiply in cell 0.
// Reset: both histories clear to zero, weight 0 returns to 1.0, others to zero,
// and the output queue empties.
// Stall: results wait in an 8-entry queue; s_tready drops once samples in the
// pipe plus queued results reach 8, so nothing is lost when m_tready is low.
// ----------------------------------------------------------------------------
module direct_form_one_iir_filter (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [15:0]                            s_tdata,   // [15:0] sample_in
  // output stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [15:0]                            m_tdata,   // [15:0] sample_out
  output logic [0:0]                             m_tuser,   // [0] clipped
  // configuration writes
  input  logic                                   cfg_we,
  input  logic [dfi_pkg::REG_IDX_W-1:0]          cfg_index,
  input  logic [dfi_pkg::COEF_W-1:0]             cfg_data
);

  // coefficient registers
  logic signed [dfi_pkg::COEF_W-1:0]   coef [dfi_pkg::NUM_REGS];

  // cell row
  logic signed [dfi_pkg::SAMPLE_W-1:0] x_hold    [dfi_pkg::HIST_DEPTH];
  logic signed [dfi_pkg::SAMPLE_W-1:0] y_hold    [dfi_pkg::HIST_DEPTH];
  logic signed [dfi_pkg::PROD_W-1:0]   feed_prod [dfi_pkg::HIST_DEPTH];
  logic signed [dfi_pkg::PROD_W-1:0]   back_prod [dfi_pkg::HIST_DEPTH];
  dfi_pkg::dfi_shift_t                 shift;

  // pipeline: v1 history shifted, v2 products ready, v3 feed sum ready
  logic                                v1;
  logic                                v2;
  logic                                v3;
  logic signed [dfi_pkg::ACC_W-1:0]    feed_sum;
  logic signed [dfi_pkg::ACC_W-1:0]    feed_sum_next;

  // recursion stage
  logic signed [dfi_pkg::ACC_W-1:0]    acc;
  logic signed [dfi_pkg::SHIFT_W-1:0]  scaled;
  logic signed [dfi_pkg::SAMPLE_W-1:0] y_new;
  logic                                clip_new;
  dfi_pkg::dfi_result_t                result;

  // output queue and flow control
  dfi_pkg::dfi_result_t                head;
  logic [dfi_pkg::CNT_W-1:0]           queued;
  logic [dfi_pkg::CNT_W:0]             load;
  logic                                in_beat;
  logic                                out_beat;

  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dfi_pkg::NUM_REGS; i++) begin
        coef[i] <= (dfi_pkg::REG_IDX_W'(i) == dfi_pkg::REG_FEED_COEF_ZERO) ?
                   dfi_pkg::COEF_UNITY : '0;
      end
    end else if (cfg_we) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Cell row: x history shifts on an input beat, y history when a result is
  // produced. Taps beyond the configured counts see a zero weight.
  // --------------------------------------------------------------------------
  assign shift.x = in_beat;
  assign shift.y = v3;

  for (genvar k = 0; k < dfi_pkg::HIST_DEPTH; k++) begin : g_cell
    logic signed [dfi_pkg::SAMPLE_W-1:0] x_left;
    logic signed [dfi_pkg::SAMPLE_W-1:0] y_left;
    logic signed [dfi_pkg::COEF_W-1:0]   feed_coef;
    logic signed [dfi_pkg::COEF_W-1:0]   back_coef;

    if (k == 0) begin : g_head
      assign x_left = s_tdata;
      assign y_left = y_new;
    end else begin : g_body
      assign x_left = x_hold[k-1];
      assign y_left = y_hold[k-1];
    end

    if (k < dfi_pkg::FEED_TAPS) begin : g_feed_on
      assign feed_coef = coef[dfi_pkg::REG_FEED_COEF_ZERO + dfi_pkg::REG_IDX_W'(k)];
    end else begin : g_feed_off
      assign feed_coef = '0;
    end

    if (k < dfi_pkg::BACK_TAPS) begin : g_back_on
      assign back_coef = coef[dfi_pkg::REG_BACK_COEF_ONE + dfi_pkg::REG_IDX_W'(k)];
    end else begin : g_back_off
      assign back_coef = '0;
    end

    dfi_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .x_left    (x_left),
      .y_left    (y_left),
      .feed_coef (feed_coef),
      .back_coef (back_coef),
      .x_hold    (x_hold[k]),
      .y_hold    (y_hold[k]),
      .feed_prod (feed_prod[k]),
      .back_prod (back_prod[k])
    );
  end

  // --------------------------------------------------------------------------
  // Feed-forward sum with the rounding bias folded in
  // --------------------------------------------------------------------------
  always_comb begin
    feed_sum_next = dfi_pkg::ROUND_HALF;
    for (int i = 0; i < dfi_pkg::HIST_DEPTH; i++) begin
      feed_sum_next = feed_sum_next + dfi_pkg::ACC_W'(feed_prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    feed_sum <= feed_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_beat;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // --------------------------------------------------------------------------
  // Recursion: subtract feedback, floor shift, saturate. y_new feeds cell 0
  // and is registered there, which closes this path.
  // --------------------------------------------------------------------------
  always_comb begin
    acc = feed_sum;
    for (int i = 0; i < dfi_pkg::HIST_DEPTH; i++) begin
      acc = acc - dfi_pkg::ACC_W'(back_prod[i]);
    end
    scaled = acc[dfi_pkg::ACC_W-1:dfi_pkg::FRAC_BITS];
    if (scaled > dfi_pkg::SHIFT_W'(dfi_pkg::SAMPLE_HI)) begin
      y_new    = dfi_pkg::SAMPLE_HI;
      clip_new = 1'b1;
    end else if (scaled < dfi_pkg::SHIFT_W'(dfi_pkg::SAMPLE_LO)) begin
      y_new    = dfi_pkg::SAMPLE_LO;
      clip_new = 1'b1;
    end else begin
      y_new    = scaled[dfi_pkg::SAMPLE_W-1:0];
      clip_new = 1'b0;
    end
  end

  assign result.clipped = clip_new;
  assign result.sample  = y_new;

  // --------------------------------------------------------------------------
  // Output queue; credit covers every sample still in the pipe
  // --------------------------------------------------------------------------
  dfi_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (v3),
    .push_data  (result),
    .pop        (m_tready),
    .head_valid (m_tvalid),
    .head_data  (head),
    .count      (queued)
  );

  assign load = {1'b0, queued}
              + (dfi_pkg::CNT_W + 1)'(v1)
              + (dfi_pkg::CNT_W + 1)'(v2)
              + (dfi_pkg::CNT_W + 1)'(v3);

  assign s_tready = !rst && (load < (dfi_pkg::CNT_W + 1)'(dfi_pkg::FIFO_DEPTH));

  assign m_tdata  = head.sample;
  assign m_tuser  = head.clipped;

endmodule

@@ hw/rtl/dfi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfi_checker: port-level checks for the direct form one IIR filter
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module dfi_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // a held output beat keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  // a clipped result sits on one of the rails
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata == 16'h7fff) || (m_tdata == 16'h8000))
    else $error("clip flag set on an unsaturated sample");

  // an output appearing from empty comes from a matching earlier input beat
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
    else $error("result appeared without a matching input beat");

  // reset empties the output side
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind direct_form_one_iir_filter dfi_checker u_dfi_checker (.*);
